### src/assert_macros.svh
// Assertion macros for the checker file of this project.
// Each macro takes a label, a clock, an active-low reset, a property or
// expression, and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or sequence property, checked at every rising clock edge.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true at a rising clock edge.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### src/sha256_pkg.sv
// Package for the SHA-256 hash engine: sequencer state type, round constants,
// initial hash values and the sigma functions.
// No dependencies.
package sha256_pkg;

  localparam int NUM_ROUNDS  = 64;
  localparam int BLOCK_WORDS = 16;
  localparam int NUM_HASH    = 8;
  localparam int PAD_LEN_POS = 56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  // Sequencer states, one-hot coded.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_FOLD  = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  localparam word_t INIT_H [NUM_HASH] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Rotate right by a constant amount.
  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  // Round constant table.
  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

### src/sha256_hash_engine_unit.sv
// SHA-256 hash engine: byte input, padding, round sequencer and digest output.
// Depends on sha256_pkg.
//
// Usage:
// - Input channel: one word per handshake carries an optional message byte
//   (in_has_byte) and an end-of-message flag (in_last). Bytes fill a 64-byte
//   block big-endian. A word with neither a byte nor last changes nothing.
// - A byte word is taken while the engine is idle. The word that completes a
//   block then holds in_stall high through 64 rounds of the shared round
//   unit, one per cycle, and a fold of the working variables into the chain
//   value; no new byte is taken until the fold is done.
// - On a word with in_last set the block pads the message. Each padding
//   block is filled, run through 64 rounds and folded; one or two are
//   needed before the digest appears (after the rounds and fold of the
//   last word's own block, if that word also completed a block).
// - Output channel: one word holding the eight digest words. It stays on the
//   ports while out_stall is high; no new input word is accepted until it
//   has been taken, after which the engine is ready for the next message.
// - Reset (synchronous, rst_n low) loads the initial hash values, clears the
//   length count and returns the sequencer to idle; no result is pending.
module sha256_hash_engine_unit
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word0,
  output logic [31:0] out_digest_word1,
  output logic [31:0] out_digest_word2,
  output logic [31:0] out_digest_word3,
  output logic [31:0] out_digest_word4,
  output logic [31:0] out_digest_word5,
  output logic [31:0] out_digest_word6,
  output logic [31:0] out_digest_word7
);

  localparam logic [5:0] RND_LAST = 6'(NUM_ROUNDS - 1);
  localparam logic [5:0] POS_LAST = 6'(BLOCK_WORDS * 4 - 1);

  // Control state.
  state_t      state_r, state_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        fin_r, fin_nxt;        // message closed, padding still owed
  logic        pad80_r, pad80_nxt;    // pad byte already placed
  logic        lendone_r, lendone_nxt; // length placed in the current block
  logic [60:0] cnt_r, cnt_nxt;        // message length in bytes
  word_t       chain_r [NUM_HASH];
  word_t       chain_nxt [NUM_HASH];

  // Datapath registers: block window doubles as the message schedule.
  word_t win_r [BLOCK_WORDS];
  word_t win_nxt [BLOCK_WORDS];
  word_t wv_r [NUM_HASH];
  word_t wv_nxt [NUM_HASH];

  logic [5:0]  pos;
  logic [63:0] len_bits;
  word_t       t1, t2, ch, maj, w_new;

  assign pos      = cnt_r[5:0];
  assign len_bits = {cnt_r, 3'b000};

  // Shared round unit and schedule expansion.
  always_comb begin
    ch    = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    maj   = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    t1    = wv_r[7] + big_sigma1(wv_r[4]) + ch + round_k(rnd_r) + win_r[0];
    t2    = big_sigma0(wv_r[0]) + maj;
    w_new = small_sigma1(win_r[14]) + win_r[9] + small_sigma0(win_r[1]) + win_r[0];
  end

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt   = state_r;
    rnd_nxt     = rnd_r;
    fin_nxt     = fin_r;
    pad80_nxt   = pad80_r;
    lendone_nxt = lendone_r;
    cnt_nxt     = cnt_r;
    chain_nxt   = chain_r;
    win_nxt     = win_r;
    wv_nxt      = wv_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_has_byte) begin
            win_nxt[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = in_data_byte;
            cnt_nxt = cnt_r + 61'd1;
          end
          if (in_has_byte && (pos == POS_LAST)) begin
            // Block full: start the rounds, finish the message afterwards.
            fin_nxt   = in_last;
            wv_nxt    = chain_r;
            rnd_nxt   = '0;
            state_nxt = ST_ROUND;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        // Pad byte after the message, zero fill, and the length if it fits.
        for (int b = 0; b < BLOCK_WORDS * 4; b++) begin
          if (pad80_r || (6'(b) > pos)) begin
            win_nxt[b / 4][(3 - (b % 4)) * 8 +: 8] = '0;
          end else if (6'(b) == pos) begin
            win_nxt[b / 4][(3 - (b % 4)) * 8 +: 8] = PAD_BYTE;
          end
        end
        if (pad80_r || (pos < 6'(PAD_LEN_POS))) begin
          win_nxt[BLOCK_WORDS - 2] = len_bits[63:32];
          win_nxt[BLOCK_WORDS - 1] = len_bits[31:0];
          lendone_nxt = 1'b1;
        end
        pad80_nxt = 1'b1;
        fin_nxt   = 1'b1;
        wv_nxt    = chain_r;
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end

      ST_ROUND: begin
        wv_nxt[7] = wv_r[6];
        wv_nxt[6] = wv_r[5];
        wv_nxt[5] = wv_r[4];
        wv_nxt[4] = wv_r[3] + t1;
        wv_nxt[3] = wv_r[2];
        wv_nxt[2] = wv_r[1];
        wv_nxt[1] = wv_r[0];
        wv_nxt[0] = t1 + t2;
        // The window slides by one word and takes the next schedule word.
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[BLOCK_WORDS - 1] = w_new;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end

      ST_FOLD: begin
        for (int i = 0; i < NUM_HASH; i++) begin
          chain_nxt[i] = chain_r[i] + wv_r[i];
        end
        if (lendone_r) begin
          state_nxt = ST_OUT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (!out_stall) begin
          chain_nxt   = INIT_H;
          cnt_nxt     = '0;
          fin_nxt     = 1'b0;
          pad80_nxt   = 1'b0;
          lendone_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rnd_r     <= '0;
      fin_r     <= 1'b0;
      pad80_r   <= 1'b0;
      lendone_r <= 1'b0;
      cnt_r     <= '0;
      chain_r   <= INIT_H;
    end else begin
      state_r   <= state_nxt;
      rnd_r     <= rnd_nxt;
      fin_r     <= fin_nxt;
      pad80_r   <= pad80_nxt;
      lendone_r <= lendone_nxt;
      cnt_r     <= cnt_nxt;
      chain_r   <= chain_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    wv_r  <= wv_nxt;
  end

  // Handshake and digest outputs.
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  assign out_digest_word0 = chain_r[0];
  assign out_digest_word1 = chain_r[1];
  assign out_digest_word2 = chain_r[2];
  assign out_digest_word3 = chain_r[3];
  assign out_digest_word4 = chain_r[4];
  assign out_digest_word5 = chain_r[5];
  assign out_digest_word6 = chain_r[6];
  assign out_digest_word7 = chain_r[7];

endmodule

### src/sha256_checker.sv
// Port-level checker for the SHA-256 hash engine, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module sha256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_has_byte,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word0,
  input logic [31:0] out_digest_word1,
  input logic [31:0] out_digest_word2,
  input logic [31:0] out_digest_word3,
  input logic [31:0] out_digest_word4,
  input logic [31:0] out_digest_word5,
  input logic [31:0] out_digest_word6,
  input logic [31:0] out_digest_word7
);

  logic [255:0] digest_all;
  logic [9:0]   in_word;

  // Whole payloads of both channels, for the hold checks.
  assign digest_all = {out_digest_word0, out_digest_word1, out_digest_word2, out_digest_word3,
                       out_digest_word4, out_digest_word5, out_digest_word6, out_digest_word7};
  assign in_word    = {in_data_byte, in_has_byte, in_last};

  // A stalled digest word stays on the ports unchanged.
  `ASSERT_PROP(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(digest_all), "digest changed while stalled")

  // A stalled input word stays on the ports unchanged.
  `ASSERT_PROP(a_in_hold, clk, rst_n, in_valid && in_stall |=> in_valid && $stable(in_word), "input word changed while stalled")

  // The engine never takes input while a digest is waiting.
  `ASSERT_NEVER(a_no_input_with_result, clk, rst_n, out_valid && !in_stall, "input open while digest pending")

  // A digest only appears after a busy period.
  `ASSERT_PROP(a_result_after_busy, clk, rst_n, $rose(out_valid) |-> $past(in_stall), "digest appeared without processing")

  // One digest per message: a taken digest is not shown again.
  `ASSERT_PROP(a_single_result, clk, rst_n, out_valid && !out_stall |=> !out_valid && !in_stall, "digest repeated")

endmodule

bind sha256_hash_engine_unit sha256_checker u_sha256_checker (.*);
